@@ design/tbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared widths, constants and controller/datapath handshake types for the
// Tanimoto bit-vector similarity block.
// ----------------------------------------------------------------------------
package tbs_pkg;

    // Word format of the incoming fingerprint pairs
    localparam int WORD_W    = 32;
    localparam int WORD_BITS = 32;
    localparam int MAX_WORDS = 32;

    // Bits of each input word that take part in the counts
    localparam logic [WORD_W-1:0] WORD_MASK =
        (WORD_BITS >= WORD_W) ? {WORD_W{1'b1}}
                              : WORD_W'((64'd1 << WORD_BITS) - 64'd1);

    // Result widths
    localparam int CNT_W = 11;
    localparam int SIM_W = 17;
    localparam int POP_W = $clog2(WORD_W + 1);
    localparam int SEEN_W = $clog2(MAX_WORDS + 1);

    localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [SIM_W-1:0]  ONE_Q16   = SIM_W'(65536);

    // Divider: numerator is count * 2^16 plus half the divisor
    localparam int FRAC_W    = 16;
    localparam int NUM_W     = CNT_W + FRAC_W;
    localparam int DIV_STEPS = SIM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Commands from controller to datapath
    typedef struct packed {
        logic acc_en;     // accept an input word pair
        logic div_load;   // snapshot totals, start divide, clear totals
        logic div_step;   // one restoring division step
        logic out_load;   // move finished result into output registers
    } tbs_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic div_last;   // current division step is the final one
    } tbs_sts_t;

    // Number of set bits in one word
    function automatic logic [POP_W-1:0] pop_count(input logic [WORD_W-1:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            n = n + POP_W'(v[i]);
        end
        return n;
    endfunction

    // Add a word count to a running total, saturating at the top
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [POP_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + (CNT_W+1)'(b);
        return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

@@ design/tbs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_ctrl
// Controller: accumulates requests, sequences the serial divide and hands
// the finished result to the output register.
// ----------------------------------------------------------------------------
module tbs_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             last_word,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output tbs_pkg::tbs_cmd_t cmd,
    input  tbs_pkg::tbs_sts_t sts
);
    import tbs_pkg::*;

    typedef enum logic [1:0] {
        ST_ACC,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_take;
    logic   out_free;

    assign in_stall  = (state_reg != ST_ACC);
    assign in_take   = in_valid && (state_reg == ST_ACC);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.acc_en   = in_take;
        case (state_reg)
            ST_ACC:
            begin
                if (in_take && last_word)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    // Output valid: set on load, cleared when the request is taken
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ design/tbs_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_dp
// Datapath: running AND/OR popcounts, restoring bit-serial divider and the
// output result registers.
// ----------------------------------------------------------------------------
module tbs_dp
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  tbs_pkg::tbs_cmd_t            cmd,
    output tbs_pkg::tbs_sts_t            sts,
    input  logic [tbs_pkg::WORD_W-1:0]   word_a,
    input  logic [tbs_pkg::WORD_W-1:0]   word_b,
    output logic [tbs_pkg::CNT_W-1:0]    common_bits,
    output logic [tbs_pkg::CNT_W-1:0]    union_bits,
    output logic [tbs_pkg::SIM_W-1:0]    similarity,
    output logic                         empty_union,
    output logic                         too_long
);
    import tbs_pkg::*;

    // Accumulator state
    logic [CNT_W-1:0]  common_total_reg, common_total_next;
    logic [CNT_W-1:0]  union_total_reg,  union_total_next;
    logic [SEEN_W-1:0] words_seen_reg,   words_seen_next;
    logic              overflowed_reg,   overflowed_next;

    // Divider state and snapshot of the finished vector
    logic [CNT_W-1:0]  rem_reg,  rem_next;
    logic [SIM_W-1:0]  quo_reg,  quo_next;
    logic [CNT_W-1:0]  den_reg,  den_next;
    logic [CNT_W-1:0]  snap_common_reg, snap_common_next;
    logic              snap_empty_reg,  snap_empty_next;
    logic              snap_over_reg,   snap_over_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // Output registers
    logic [CNT_W-1:0]  common_out_reg, common_out_next;
    logic [CNT_W-1:0]  union_out_reg,  union_out_next;
    logic [SIM_W-1:0]  sim_out_reg,    sim_out_next;
    logic              empty_out_reg,  empty_out_next;
    logic              over_out_reg,   over_out_next;

    logic [WORD_W-1:0] a_m, b_m;
    logic [POP_W-1:0]  and_cnt, or_cnt;
    logic [NUM_W-1:0]  num;
    logic [CNT_W:0]    trial;
    logic              q_bit;
    logic [SIM_W-1:0]  sim_clamped;

    // Word popcounts
    assign a_m     = word_a & WORD_MASK;
    assign b_m     = word_b & WORD_MASK;
    assign and_cnt = pop_count(a_m & b_m);
    assign or_cnt  = pop_count(a_m | b_m);

    // Rounded numerator: common * 2^16 + union / 2
    assign num = {common_total_reg, {FRAC_W{1'b0}}}
               + NUM_W'(union_total_reg >> 1);

    // One restoring divide step
    assign trial = {rem_reg, quo_reg[SIM_W-1]};
    assign q_bit = (trial >= {1'b0, den_reg});

    assign sim_clamped  = (quo_reg > ONE_Q16) ? ONE_Q16 : quo_reg;
    assign sts.div_last = (step_reg == STEP_W'(DIV_STEPS - 1));

    // Accumulators
    always_comb
    begin
        common_total_next = common_total_reg;
        union_total_next  = union_total_reg;
        words_seen_next   = words_seen_reg;
        overflowed_next   = overflowed_reg;
        if (cmd.div_load)
        begin
            common_total_next = '0;
            union_total_next  = '0;
            words_seen_next   = '0;
            overflowed_next   = 1'b0;
        end
        else if (cmd.acc_en)
        begin
            if (words_seen_reg < SEEN_W'(MAX_WORDS))
            begin
                common_total_next = sat_add(common_total_reg, and_cnt);
                union_total_next  = sat_add(union_total_reg, or_cnt);
                words_seen_next   = words_seen_reg + 1'b1;
            end
            else
            begin
                overflowed_next = 1'b1;
            end
        end
    end

    // Divider
    always_comb
    begin
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        den_next         = den_reg;
        step_next        = step_reg;
        snap_common_next = snap_common_reg;
        snap_empty_next  = snap_empty_reg;
        snap_over_next   = snap_over_reg;
        if (cmd.div_load)
        begin
            // Quotient fits in SIM_W bits, so the top bits start as remainder
            rem_next         = CNT_W'(num >> SIM_W);
            quo_next         = num[SIM_W-1:0];
            den_next         = union_total_reg;
            step_next        = '0;
            snap_common_next = common_total_reg;
            snap_empty_next  = (union_total_reg == '0);
            snap_over_next   = overflowed_reg;
        end
        else if (cmd.div_step)
        begin
            rem_next  = q_bit ? CNT_W'(trial - {1'b0, den_reg}) : trial[CNT_W-1:0];
            quo_next  = {quo_reg[SIM_W-2:0], q_bit};
            step_next = step_reg + 1'b1;
        end
    end

    // Result registers
    always_comb
    begin
        common_out_next = common_out_reg;
        union_out_next  = union_out_reg;
        sim_out_next    = sim_out_reg;
        empty_out_next  = empty_out_reg;
        over_out_next   = over_out_reg;
        if (cmd.out_load)
        begin
            common_out_next = snap_common_reg;
            union_out_next  = den_reg;
            sim_out_next    = snap_empty_reg ? '0 : sim_clamped;
            empty_out_next  = snap_empty_reg;
            over_out_next   = snap_over_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            common_total_reg <= '0;
            union_total_reg  <= '0;
            words_seen_reg   <= '0;
            overflowed_reg   <= 1'b0;
            step_reg         <= '0;
        end
        else
        begin
            common_total_reg <= common_total_next;
            union_total_reg  <= union_total_next;
            words_seen_reg   <= words_seen_next;
            overflowed_reg   <= overflowed_next;
            step_reg         <= step_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        den_reg         <= den_next;
        snap_common_reg <= snap_common_next;
        snap_empty_reg  <= snap_empty_next;
        snap_over_reg   <= snap_over_next;
        common_out_reg  <= common_out_next;
        union_out_reg   <= union_out_next;
        sim_out_reg     <= sim_out_next;
        empty_out_reg   <= empty_out_next;
        over_out_reg    <= over_out_next;
    end

    assign common_bits = common_out_reg;
    assign union_bits  = union_out_reg;
    assign similarity  = sim_out_reg;
    assign empty_union = empty_out_reg;
    assign too_long    = over_out_reg;

endmodule

@@ design/tanimoto_bitvector_similarity.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tanimoto_bitvector_similarity
// Tanimoto coefficient of two streamed bit-vector fingerprints, in Q1.16.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------
//   in      | into      | in_valid/in_stall  | word_a, word_b, last_word
//   out     | out of    | out_valid/out_stall| common_bits, union_bits,
//           |           |                    | similarity, empty_union, too_long
//
// A word pair without last_word is taken whenever it is offered. After a
// last pair in_stall stays high through the load, the restoring divide,
// one quotient bit a cycle, and the hand-off to the output register.
// The output register holds a result under out_stall while the next vector
// accumulates; a finished divide waits in the controller until it is free.
// Reset is asynchronous, active low, and clears counts and handshakes.
// ----------------------------------------------------------------------------
module tanimoto_bitvector_similarity
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [tbs_pkg::WORD_W-1:0]   word_a,
    input  logic [tbs_pkg::WORD_W-1:0]   word_b,
    input  logic                         last_word,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [tbs_pkg::CNT_W-1:0]    common_bits,
    output logic [tbs_pkg::CNT_W-1:0]    union_bits,
    output logic [tbs_pkg::SIM_W-1:0]    similarity,
    output logic                         empty_union,
    output logic                         too_long
);
    import tbs_pkg::*;

    tbs_cmd_t cmd;
    tbs_sts_t sts;

    // Sequencer
    tbs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_word (last_word),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Counts, divider and result registers
    tbs_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .word_a      (word_a),
        .word_b      (word_b),
        .common_bits (common_bits),
        .union_bits  (union_bits),
        .similarity  (similarity),
        .empty_union (empty_union),
        .too_long    (too_long)
    );

endmodule

@@ design/tbs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_checker
// Port-level checks on the similarity block, bound to the top level.
// ----------------------------------------------------------------------------
module tbs_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [tbs_pkg::CNT_W-1:0]    common_bits,
    input logic [tbs_pkg::CNT_W-1:0]    union_bits,
    input logic [tbs_pkg::SIM_W-1:0]    similarity,
    input logic                         empty_union
);
    import tbs_pkg::*;

    // A stalled result request stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result request dropped under stall");

    // AND count never exceeds OR count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> common_bits <= union_bits)
        else $error("common count above union count");

    // Empty flag matches union and forces a zero ratio
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (empty_union == (union_bits == '0))
                      && (!empty_union || similarity == '0))
        else $error("empty union flag inconsistent");

    // Ratio never above one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> similarity <= ONE_Q16)
        else $error("similarity above one");

    // Identical counts give exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !empty_union && common_bits == union_bits
            |-> similarity == ONE_Q16)
        else $error("equal counts do not give one");

endmodule

bind tanimoto_bitvector_similarity tbs_checker u_tbs_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .common_bits (common_bits),
    .union_bits  (union_bits),
    .similarity  (similarity),
    .empty_union (empty_union)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for tanimoto_bitvector_similarity. Fingerprint word
// pairs are streamed over the valid/stall request port. A tracker keeps its
// own running AND/OR popcounts and works out the Q1.16 ratio for each
// vector. Every result is then compared in order, field by field. The run
// goes through three idling mixes, long receiver hold-offs and full drains.
// ----------------------------------------------------------------------------
module tb_top;
    import tbs_pkg::*;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 30;
    localparam int PHASE_ITEMS     = 550;

    // One expected or observed result
    typedef struct packed {
        logic [CNT_W-1:0] common;
        logic [CNT_W-1:0] either;
        logic [SIM_W-1:0] ratio;
        logic             empty;
        logic             too_long;
    } score_t;

    typedef enum int {W_RANDOM, W_ZERO, W_ONES, W_SAME, W_INVERSE, W_SPARSE} word_kind_t;
    typedef enum int {VEC_MIXED, VEC_ZERO, VEC_SAME, VEC_ONES} vec_kind_t;

    // Running popcounts per vector and the queue of scores still to arrive
    class tanimoto_tracker;
        localparam int MAX_REPORTS = 30;

        logic [CNT_W-1:0] and_total;
        logic [CNT_W-1:0] or_total;
        int               pairs_seen;
        bit               past_limit;
        score_t           pending_scores[$];
        int               errors;

        function new();
            clear_vector();
            errors = 0;
        endfunction

        function void clear_vector();
            and_total  = '0;
            or_total   = '0;
            pairs_seen = 0;
            past_limit = 1'b0;
        endfunction

        function logic [CNT_W-1:0] add_count(logic [CNT_W-1:0] total, int ones);
            int s;
            s = int'(total) + ones;
            return (s > int'(COUNT_MAX)) ? COUNT_MAX : CNT_W'(s);
        endfunction

        // Accepted word pair: accumulate, and on the last pair queue a score
        function void note_request(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
                                   logic last);
            logic [WORD_W-1:0] ma;
            logic [WORD_W-1:0] mb;
            score_t            s;
            longint            num;
            longint            q;
            ma = a & WORD_MASK;
            mb = b & WORD_MASK;
            if (pairs_seen < MAX_WORDS)
            begin
                and_total = add_count(and_total, $countones(ma & mb));
                or_total  = add_count(or_total, $countones(ma | mb));
                pairs_seen++;
            end
            else
            begin
                past_limit = 1'b1;
            end
            if (last)
            begin
                s.common   = and_total;
                s.either   = or_total;
                s.empty    = (or_total == '0);
                s.too_long = past_limit;
                if (s.empty)
                begin
                    s.ratio = '0;
                end
                else
                begin
                    // round to nearest, halves up
                    num = longint'(and_total) * 65536 + longint'(or_total >> 1);
                    q   = num / longint'(or_total);
                    s.ratio = (q > 65536) ? ONE_Q16 : SIM_W'(q);
                end
                pending_scores.insert(pending_scores.size(), s);
                clear_vector();
            end
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: mismatch: %s", $time, what);
        endtask

        task check_result(score_t got);
            score_t want;
            if (pending_scores.size() == 0)
            begin
                report_mismatch("result arrived with nothing expected");
                return;
            end
            want = pending_scores.pop_front();
            if (got.common !== want.common)
                report_mismatch($sformatf("common_bits %0d, expected %0d",
                                          got.common, want.common));
            if (got.either !== want.either)
                report_mismatch($sformatf("union_bits %0d, expected %0d",
                                          got.either, want.either));
            if (got.ratio !== want.ratio)
                report_mismatch($sformatf("similarity %0d, expected %0d",
                                          got.ratio, want.ratio));
            if (got.empty !== want.empty)
                report_mismatch($sformatf("empty_union %b, expected %b",
                                          got.empty, want.empty));
            if (got.too_long !== want.too_long)
                report_mismatch($sformatf("too_long %b, expected %b",
                                          got.too_long, want.too_long));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [WORD_W-1:0]  word_a;
    logic [WORD_W-1:0]  word_b;
    logic               last_word;
    logic               out_valid;
    logic               out_stall;
    logic [CNT_W-1:0]   common_bits;
    logic [CNT_W-1:0]   union_bits;
    logic [SIM_W-1:0]   similarity;
    logic               empty_union;
    logic               too_long;

    tanimoto_tracker tracker = new();

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int items_sent   = 0;
    bit hold_off_req = 1'b0;

    tanimoto_bitvector_similarity DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .word_a      (word_a),
        .word_b      (word_b),
        .last_word   (last_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .common_bits (common_bits),
        .union_bits  (union_bits),
        .similarity  (similarity),
        .empty_union (empty_union),
        .too_long    (too_long)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Both handshakes observed at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            tracker.note_request(word_a, word_b, last_word);
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(score_t'({common_bits, union_bits, similarity,
                                           empty_union, too_long}));
    end

    // Receiver: random stalls, plus a long hold-off when asked for
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_left    = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    // Offer one word pair and wait until it is taken; starts and ends at a falling edge
    task automatic send_pair(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b, logic last);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid  <= 1'b0;
            word_a    <= $urandom;
            word_b    <= $urandom;
            last_word <= 1'($urandom_range(0, 1));
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        word_a    <= a;
        word_b    <= b;
        last_word <= last;
        items_sent++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // One whole fingerprint pair of the given length
    task automatic send_vector(int len, vec_kind_t kind);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        for (int i = 0; i < len; i++)
        begin
            a = $urandom;
            b = $urandom;
            case (kind)
                VEC_ZERO:
                begin
                    a = '0;
                    b = '0;
                end
                VEC_ONES:
                begin
                    a = '1;
                    b = '1;
                end
                VEC_SAME: b = a;
                default:
                begin
                    case (word_kind_t'($urandom_range(0, 5)))
                        W_ZERO:
                        begin
                            a = '0;
                            b = '0;
                        end
                        W_ONES:
                        begin
                            a = '1;
                            b = '1;
                        end
                        W_SAME:    b = a;
                        W_INVERSE: b = ~a;
                        W_SPARSE:
                        begin
                            a = a & $urandom & $urandom;
                            b = b & $urandom & $urandom;
                        end
                        default: ;
                    endcase
                end
            endcase
            send_pair(a, b, i == len - 1);
        end
    endtask

    // Mostly short vectors, some full length, a few past MAX_WORDS
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(1, 4);
        else if (r < 85)
            return $urandom_range(5, 16);
        else if (r < 95)
            return $urandom_range(17, MAX_WORDS);
        else
            return $urandom_range(MAX_WORDS + 1, MAX_WORDS + 8);
    endfunction

    function automatic vec_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return VEC_ZERO;
            1:       return VEC_SAME;
            2:       return VEC_ONES;
            default: return VEC_MIXED;
        endcase
    endfunction

    // Sender pauses until every score is in, then lets the divider settle
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending_scores.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int phase_start;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        word_a    = '0;
        word_b    = '0;
        last_word = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty union, full overlap, disjoint, half, rounding
        send_pair('0, '0, 1'b1);
        send_pair('1, '1, 1'b1);
        send_pair('1, '0, 1'b1);
        send_pair('0, '1, 1'b1);
        send_pair(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
        send_pair(32'hAAAA_AAAA, 32'hFFFF_FFFF, 1'b1);
        send_pair(32'h0000_0001, 32'h0000_0007, 1'b1);
        // 2/3 rounds up
        send_pair(32'h0000_0003, 32'h0000_0001, 1'b0);
        send_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_pair(32'h8000_0000, 32'h8000_0000, 1'b1);
        // multi-word vector that stays empty
        send_vector(3, VEC_ZERO);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 33;
                    rx_idle_pct = 73;
                end
                1:
                begin
                    tx_idle_pct = 73;
                    rx_idle_pct = 33;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            // long receiver hold-off while the sender keeps going
            if (phase < 2)
                hold_off_req = 1'b1;
            phase_start = items_sent;
            if (phase == 0)
            begin
                // one word past the limit, then the largest possible counts
                send_vector(MAX_WORDS + 1, VEC_MIXED);
                send_vector(MAX_WORDS, VEC_ONES);
            end
            while (items_sent - phase_start < PHASE_ITEMS)
                send_vector(pick_length(), pick_kind());
            drain();
        end

        if (tracker.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
design/tbs_pkg.sv
design/tbs_ctrl.sv
design/tbs_dp.sv
design/tanimoto_bitvector_similarity.sv
design/tbs_checker.sv
tb/sv/tb_top.sv
